FILE: rtl/core/safs_pkg.sv
`default_nettype none

package safs_pkg;

   // largest frame count the animation can use
   localparam logic [8:0] MAX_FRAMES = 9'd256;

   typedef enum logic [2:0] {
      REG_FRAME_PERIOD   = 3'd0,
      REG_NUM_FRAMES     = 3'd1,
      REG_FRAMES_PER_ROW = 3'd2,
      REG_CYCLIC         = 3'd3,
      REG_START_X        = 3'd4,
      REG_START_Y        = 3'd5,
      REG_PITCH_X        = 3'd6,
      REG_PITCH_Y        = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] frame_period;
      logic [8:0]  num_frames;
      logic [8:0]  frames_per_row;
      logic        cyclic;
      logic [11:0] start_x;
      logic [11:0] start_y;
      logic [11:0] pitch_x;
      logic [11:0] pitch_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_period:   16'd1,
      num_frames:     9'd1,
      frames_per_row: 9'd1,
      cyclic:         1'b1,
      start_x:        12'd0,
      start_y:        12'd0,
      pitch_x:        12'd0,
      pitch_y:        12'd0
   };

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic restart;
      logic add;
      logic div_start;
      logic div_step;
      logic step;
      logic pos_start;
      logic pos_step;
      logic mul;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic restart;
      logic skip;
      logic short_tick;
      logic cnt_zero;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/sprite_animation_frame_stepper_core.sv
// sprite animation frame stepper
//
// req channel: one beat per item, req_op 0 adds req_delta_time ticks to the time
// accumulator, req_op 1 restarts at frame zero. a beat is taken when req_valid
// is high and req_stall low; req_stall is high while an item is being worked.
// rsp channel: exactly one beat per item with the frame index, its sheet
// position and the finished / frame_changed flags, held while rsp_stall is high.
// csr port: apb-style, register i at byte address 4*i, pready tied high;
// write registers only while the block is idle.
// paths: a restart, a paused tick or a tick on a finished acyclic run skips the
// divide and goes straight to the position step, as does a tick short of a whole
// period; an advancing tick runs the bit-serial period divider, one quotient bit
// a cycle, then an 8-step frame-per-row divider and one multiply stage.
// one item in flight; the next beat is taken the cycle after the result is loaded;
// while the receiver stalls, a finished item waits for the output register and
// req_stall stays high.
// reset (synchronous) clears the frame and accumulator and loads the
// register defaults: period 1, one frame, one frame per row, cyclic.
`default_nettype none

module sprite_animation_frame_stepper_core #(
   parameter int unsigned TIME_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beats
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [15:0] req_delta_time,
   // response beats
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_index,
   output logic [20:0]      rsp_pos_x,
   output logic [20:0]      rsp_pos_y,
   output logic             rsp_finished,
   output logic             rsp_frame_changed,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import safs_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   safs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencing of the item through evaluate, divide, step, position, output
   safs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulator, frame state, dividers, multipliers and output register
   safs_dpath #(
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_delta_time    (req_delta_time),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_finished      (rsp_finished),
      .rsp_frame_changed (rsp_frame_changed)
   );

endmodule

`default_nettype wire

FILE: rtl/core/safs_csr.sv
`default_nettype none

module safs_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output safs_pkg::cfg_type     cfg
);
   import safs_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FRAME_PERIOD:   cfg_in.frame_period   = csr_pwdata[15:0];
            REG_NUM_FRAMES:     cfg_in.num_frames     = csr_pwdata[8:0];
            REG_FRAMES_PER_ROW: cfg_in.frames_per_row = csr_pwdata[8:0];
            REG_CYCLIC:         cfg_in.cyclic         = csr_pwdata[0];
            REG_START_X:        cfg_in.start_x        = csr_pwdata[11:0];
            REG_START_Y:        cfg_in.start_y        = csr_pwdata[11:0];
            REG_PITCH_X:        cfg_in.pitch_x        = csr_pwdata[11:0];
            REG_PITCH_Y:        cfg_in.pitch_y        = csr_pwdata[11:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FRAME_PERIOD:   csr_prdata = {16'd0, cfg_ff.frame_period};
         REG_NUM_FRAMES:     csr_prdata = {23'd0, cfg_ff.num_frames};
         REG_FRAMES_PER_ROW: csr_prdata = {23'd0, cfg_ff.frames_per_row};
         REG_CYCLIC:         csr_prdata = {31'd0, cfg_ff.cyclic};
         REG_START_X:        csr_prdata = {20'd0, cfg_ff.start_x};
         REG_START_Y:        csr_prdata = {20'd0, cfg_ff.start_y};
         REG_PITCH_X:        csr_prdata = {20'd0, cfg_ff.pitch_x};
         REG_PITCH_Y:        csr_prdata = {20'd0, cfg_ff.pitch_y};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/safs_ctrl.sv
`default_nettype none

module safs_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire safs_pkg::status_type status,
   output safs_pkg::cmd_type      cmd
);
   import safs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CHECK,
      ST_DIV,
      ST_STEP,
      ST_PSTART,
      ST_POS,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      mul_ff;
   logic      mul_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      mul_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.restart) begin
               cmd.restart = 1'b1;
               state_in    = ST_PSTART;
            end else if (status.skip) begin
               state_in = ST_PSTART;
            end else begin
               cmd.add  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.short_tick) begin
               state_in = ST_PSTART;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_PSTART;
         end
         ST_PSTART: begin
            cmd.pos_start = 1'b1;
            state_in      = ST_POS;
         end
         ST_POS: begin
            cmd.pos_step = 1'b1;
            if (status.cnt_zero) begin
               mul_in   = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // first cycle here forms the products, output waits for a free register
            if (mul_ff) begin
               cmd.mul = 1'b1;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_ff       <= mul_in;
      end
   end

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EVAL))
      else $error("accepted beat did not start evaluation");

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !status.cnt_zero) |=> (state_ff == ST_DIV))
      else $error("divider left before last step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result load did not raise valid");

   a_mul_before_load: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> !mul_ff)
      else $error("product stage repeated");

endmodule

`default_nettype wire

FILE: rtl/core/safs_dpath.sv
`default_nettype none

module safs_dpath #(
   parameter int unsigned TIME_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire safs_pkg::cfg_type    cfg,
   input  wire safs_pkg::cmd_type    cmd,
   output safs_pkg::status_type      status,
   input  wire logic                 req_op,
   input  wire logic [15:0]          req_delta_time,
   output logic [7:0]                rsp_frame_index,
   output logic [20:0]               rsp_pos_x,
   output logic [20:0]               rsp_pos_y,
   output logic                      rsp_finished,
   output logic                      rsp_frame_changed
);
   import safs_pkg::*;

   localparam int unsigned AccW = TIME_BITS + 1;
   localparam int unsigned CmpW = (AccW > 16) ? AccW : 16;
   localparam int unsigned SumW = AccW + 1;
   localparam int unsigned CntW = $clog2(AccW);

   // animation state
   logic [7:0]      frame_ff, frame_in;
   logic [AccW-1:0] acc_ff, acc_in;

   // item and working registers
   logic            op_ff;
   logic [15:0]     delta_ff;
   logic [AccW-1:0] quo_ff, quo_in;
   logic [15:0]     rem_ff, rem_in;
   logic [7:0]      qmod_ff, qmod_in;
   logic [7:0]      fmod_ff, fmod_in;
   logic [7:0]      fsh_ff, fsh_in;
   logic [3:0]      fcnt_ff, fcnt_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [7:0]      psh_ff, psh_in;
   logic [7:0]      prem_ff, prem_in;
   logic [19:0]     prodx_ff, prody_ff;
   logic            fin_ff, fin_in;
   logic            chg_ff, chg_in;

   logic [8:0]      eff_n;
   logic [8:0]      eff_fpr;
   logic [7:0]      last;
   logic [AccW-1:0] acc_sum;
   logic [16:0]     rem_sh;
   logic [16:0]     rem_diff;
   logic            ge;
   logic [8:0]      qm_t;
   logic [8:0]      fm_t;
   logic [8:0]      pm_t;
   logic            pge;
   logic [8:0]      cyc_sum;
   logic [8:0]      cyc_red;
   logic [SumW-1:0] lin_sum;
   logic            lin_fin;

   always_comb begin
      if (cfg.num_frames == 9'd0) begin
         eff_n = 9'd1;
      end else if (cfg.num_frames > MAX_FRAMES) begin
         eff_n = MAX_FRAMES;
      end else begin
         eff_n = cfg.num_frames;
      end
   end

   assign eff_fpr = (cfg.frames_per_row == 9'd0) ? 9'd1 : cfg.frames_per_row;
   assign last    = 8'(eff_n - 9'd1);
   assign acc_sum = acc_ff + AccW'(delta_ff);

   assign status.restart    = op_ff;
   assign status.skip       = (cfg.frame_period == 16'd0) ||
                              (!cfg.cyclic && frame_ff == last);
   assign status.short_tick = CmpW'(acc_ff) < CmpW'(cfg.frame_period);
   assign status.cnt_zero   = (cnt_ff == '0);

   // restoring divide step, quotient bits also reduced mod frame count
   assign rem_sh   = {rem_ff, quo_ff[AccW-1]};
   assign rem_diff = rem_sh - {1'b0, cfg.frame_period};
   assign ge       = rem_sh >= {1'b0, cfg.frame_period};
   assign qm_t     = {qmod_ff, ge};
   assign fm_t     = {fmod_ff, fsh_ff[7]};

   // frame to column and row
   assign pm_t = {prem_ff, psh_ff[7]};
   assign pge  = pm_t >= eff_fpr;

   // new frame, wrapping or clamping
   assign cyc_sum = {1'b0, fmod_ff} + {1'b0, qmod_ff};
   assign cyc_red = (cyc_sum >= eff_n) ? (cyc_sum - eff_n) : cyc_sum;
   assign lin_sum = SumW'(frame_ff) + SumW'(quo_ff);
   assign lin_fin = lin_sum >= SumW'(last);

   always_comb begin
      frame_in = frame_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      qmod_in  = qmod_ff;
      fmod_in  = fmod_ff;
      fsh_in   = fsh_ff;
      fcnt_in  = fcnt_ff;
      cnt_in   = cnt_ff;
      psh_in   = psh_ff;
      prem_in  = prem_ff;
      fin_in   = fin_ff;
      chg_in   = chg_ff;

      if (cmd.load_item) begin
         fin_in = 1'b0;
         chg_in = 1'b0;
      end
      if (cmd.restart) begin
         frame_in = 8'd0;
         chg_in   = 1'b1;
      end
      if (cmd.add) begin
         acc_in = acc_sum;
      end
      if (cmd.div_start) begin
         quo_in  = acc_ff;
         rem_in  = 16'd0;
         qmod_in = 8'd0;
         fmod_in = 8'd0;
         fsh_in  = frame_ff;
         fcnt_in = 4'd8;
         cnt_in  = CntW'(AccW - 1);
      end
      if (cmd.div_step) begin
         quo_in  = {quo_ff[AccW-2:0], ge};
         rem_in  = ge ? rem_diff[15:0] : rem_sh[15:0];
         qmod_in = (qm_t >= eff_n) ? 8'(qm_t - eff_n) : qm_t[7:0];
         cnt_in  = cnt_ff - 1'b1;
         if (fcnt_ff != 4'd0) begin
            fmod_in = (fm_t >= eff_n) ? 8'(fm_t - eff_n) : fm_t[7:0];
            fsh_in  = {fsh_ff[6:0], 1'b0};
            fcnt_in = fcnt_ff - 4'd1;
         end
      end
      if (cmd.step) begin
         acc_in = AccW'(rem_ff);
         chg_in = 1'b1;
         if (cfg.cyclic) begin
            frame_in = cyc_red[7:0];
            fin_in   = 1'b0;
         end else begin
            frame_in = lin_fin ? last : lin_sum[7:0];
            fin_in   = lin_fin;
         end
      end
      if (cmd.pos_start) begin
         psh_in  = frame_ff;
         prem_in = 8'd0;
         cnt_in  = CntW'(7);
      end
      if (cmd.pos_step) begin
         psh_in  = {psh_ff[6:0], pge};
         prem_in = pge ? 8'(pm_t - eff_fpr) : pm_t[7:0];
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= 8'd0;
         acc_ff   <= '0;
      end else begin
         frame_ff <= frame_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= req_op;
         delta_ff <= req_delta_time;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      qmod_ff <= qmod_in;
      fmod_ff <= fmod_in;
      fsh_ff  <= fsh_in;
      fcnt_ff <= fcnt_in;
      cnt_ff  <= cnt_in;
      psh_ff  <= psh_in;
      prem_ff <= prem_in;
      fin_ff  <= fin_in;
      chg_ff  <= chg_in;
      if (cmd.mul) begin
         prodx_ff <= 20'(prem_ff) * 20'(cfg.pitch_x);
         prody_ff <= 20'(psh_ff) * 20'(cfg.pitch_y);
      end
      if (cmd.out_load) begin
         rsp_frame_index   <= frame_ff;
         rsp_pos_x         <= 21'(cfg.start_x) + 21'(prodx_ff);
         rsp_pos_y         <= 21'(cfg.start_y) + 21'(prody_ff);
         rsp_finished      <= fin_ff;
         rsp_frame_changed <= chg_ff;
      end
   end

   a_frame_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> ({1'b0, frame_ff} < eff_n))
      else $error("stepped frame beyond frame count");

   a_rem_below_period: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (rem_ff < cfg.frame_period))
      else $error("divider remainder not below period");

   a_flags_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> (!fin_ff && !chg_ff))
      else $error("result flags not cleared for new beat");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import safs_pkg::*;

   // op codes of a request beat
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // run shape
   localparam int RANDOM_ITEMS = 1250;
   localparam int CALM_AFTER   = 1050;   // no idling from here on
   localparam int LONG_HOLD    = 200;    // long receiver hold-off, in cycles
   localparam int TAIL_CYCLES  = 40;     // longest latency plus margin
   localparam int MAX_PRINTS   = 50;

   // one expected response beat
   typedef struct packed {
      logic [7:0]  frame;
      logic [20:0] x;
      logic [20:0] y;
      logic        fin;
      logic        chg;
   } frame_pos_type;

   localparam frame_pos_type FP_NONE = '0;

   // directed stimulus rows
   typedef enum logic [1:0] {
      ROW_ITEM,      // beat checked against the predictor
      ROW_CHECKED,   // beat with its response typed in
      ROW_CSR        // register write once the block is idle
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic          op;
      logic [15:0]   dt;
      reg_idx_type   ridx;
      logic [15:0]   wval;
      frame_pos_type want;
   } dir_row_type;

   localparam int N_DIRECTED = 41;

   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      // reset settings: period 1, one frame, everything at the origin
      '{ROW_CHECKED, OP_TICK,    16'd0,     REG_FRAME_PERIOD, 16'd0, '{8'd0, 21'd0, 21'd0, 1'b0, 1'b0}},
      '{ROW_CHECKED, OP_TICK,    16'd65535, REG_FRAME_PERIOD, 16'd0, '{8'd0, 21'd0, 21'd0, 1'b0, 1'b1}},
      '{ROW_CHECKED, OP_RESTART, 16'd0,     REG_FRAME_PERIOD, 16'd0, '{8'd0, 21'd0, 21'd0, 1'b0, 1'b1}},
      '{ROW_CHECKED, OP_RESTART, 16'd65535, REG_FRAME_PERIOD, 16'd0, '{8'd0, 21'd0, 21'd0, 1'b0, 1'b1}},
      // paused
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAME_PERIOD, 16'd0, FP_NONE},
      '{ROW_CHECKED, OP_TICK,    16'd65535, REG_FRAME_PERIOD, 16'd0, '{8'd0, 21'd0, 21'd0, 1'b0, 1'b0}},
      // acyclic, four frames two to a row, far corner of the sheet
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAME_PERIOD,   16'd3,    FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_NUM_FRAMES,     16'd4,    FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAMES_PER_ROW, 16'd2,    FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_CYCLIC,         16'd0,    FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_START_X,        16'd4095, FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_START_Y,        16'd4095, FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_PITCH_X,        16'd4095, FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_PITCH_Y,        16'd4095, FP_NONE},
      // short tick, one step, clamp with finished, stuck at the end, restart
      '{ROW_CHECKED, OP_TICK, 16'd2,     REG_FRAME_PERIOD, 16'd0,
        '{8'd0, 21'd4095, 21'd4095, 1'b0, 1'b0}},
      '{ROW_CHECKED, OP_TICK, 16'd1,     REG_FRAME_PERIOD, 16'd0,
        '{8'd1, 21'd8190, 21'd4095, 1'b0, 1'b1}},
      '{ROW_CHECKED, OP_TICK, 16'd65535, REG_FRAME_PERIOD, 16'd0,
        '{8'd3, 21'd8190, 21'd8190, 1'b1, 1'b1}},
      '{ROW_CHECKED, OP_TICK, 16'd5,     REG_FRAME_PERIOD, 16'd0,
        '{8'd3, 21'd8190, 21'd8190, 1'b0, 1'b0}},
      '{ROW_CHECKED, OP_RESTART, 16'd0,  REG_FRAME_PERIOD, 16'd0,
        '{8'd0, 21'd4095, 21'd4095, 1'b0, 1'b1}},
      // zero frame count acts as one
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_NUM_FRAMES,     16'd0,     FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_CYCLIC,         16'd1,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd7,     REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      // oversized count clamps to the maximum, zero row width acts as one
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_NUM_FRAMES,     16'd511,   FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAMES_PER_ROW, 16'd0,     FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAME_PERIOD,   16'd1,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd255,   REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd1,     REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      // widest sheet, longest period
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_NUM_FRAMES,     16'd256,   FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAMES_PER_ROW, 16'd256,   FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAME_PERIOD,   16'd65535, FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd65535, REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd65534, REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd1,     REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      // park far out, then shrink the count under the held frame
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_FRAME_PERIOD,   16'd1,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd200,   REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_NUM_FRAMES,     16'd5,     FP_NONE},
      '{ROW_CSR,     OP_TICK,    16'd0,     REG_CYCLIC,         16'd0,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd0,     REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd1,     REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      '{ROW_ITEM,    OP_TICK,    16'd3,     REG_FRAME_PERIOD,   16'd0,     FP_NONE},
      '{ROW_ITEM,    OP_RESTART, 16'd0,     REG_FRAME_PERIOD,   16'd0,     FP_NONE}
   };

   // clock, reset and block inputs, all known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_op = 1'b0;
   logic [15:0] req_delta_time = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;

   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_frame_index;
   logic [20:0] rsp_pos_x;
   logic [20:0] rsp_pos_y;
   logic        rsp_finished;
   logic        rsp_frame_changed;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shared between the stimulus and the receiver
   bit idle_on  = 1'b0;   // random idling on both sides
   bit hold_rsp = 1'b0;   // ask the receiver for one long hold-off

   int error_count = 0;
   int total_items = 0;

   // predictor state: register copy, frame on show, time accumulator
   cfg_type     sheet_cfg;
   logic [7:0]  shown_frame;
   logic [16:0] tick_acc;

   // responses still owed by the block, oldest first
   frame_pos_type pending_frames [$];

   sprite_animation_frame_stepper_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_delta_time    (req_delta_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_finished      (rsp_finished),
      .rsp_frame_changed (rsp_frame_changed),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $time, what);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   function automatic logic [31:0] reg_field_mask(input reg_idx_type idx);
      case (idx)
         REG_FRAME_PERIOD:   return 32'h0000_FFFF;
         REG_NUM_FRAMES,
         REG_FRAMES_PER_ROW: return 32'h0000_01FF;
         REG_CYCLIC:         return 32'h0000_0001;
         default:            return 32'h0000_0FFF;
      endcase
   endfunction

   // advance the animation by one beat and give the response it owes
   function automatic frame_pos_type step_animation(input logic op, input logic [15:0] dt);
      int unsigned   frames, last, period, advance, nxt, row_w, col, row;
      frame_pos_type res;
      frames = sheet_cfg.num_frames;
      if (frames == 0) frames = 1;
      if (frames > MAX_FRAMES) frames = MAX_FRAMES;
      last   = frames - 1;
      period = sheet_cfg.frame_period;
      res    = FP_NONE;
      if (op == OP_RESTART) begin
         // accumulator is kept on restart
         shown_frame = '0;
         res.chg = 1'b1;
      end else if (period != 0 && !(!sheet_cfg.cyclic && shown_frame == last)) begin
         tick_acc = tick_acc + dt;
         if (tick_acc >= period) begin
            advance  = tick_acc / period;
            tick_acc = tick_acc % period;
            nxt = shown_frame + advance;
            if (sheet_cfg.cyclic) begin
               nxt = nxt % frames;
            end else begin
               // clamp at the last frame, a frame beyond the count clamps too
               if (nxt > last) nxt = last;
               res.fin = (nxt == last);
            end
            shown_frame = nxt[7:0];
            res.chg = 1'b1;
         end
      end
      // sheet position of the frame now on show
      row_w = (sheet_cfg.frames_per_row == 0) ? 1 : sheet_cfg.frames_per_row;
      col   = shown_frame % row_w;
      row   = shown_frame / row_w;
      res.frame = shown_frame;
      res.x = 21'(sheet_cfg.start_x + col * sheet_cfg.pitch_x);
      res.y = 21'(sheet_cfg.start_y + row * sheet_cfg.pitch_y);
      return res;
   endfunction

   // apb write, then read back the same register
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] val);
      logic [31:0] fmask;
      fmask = reg_field_mask(idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      // junk above the field must be dropped by the block
      csr_pwdata  <= (val & fmask) | ($urandom() & ~fmask);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_FRAME_PERIOD:   sheet_cfg.frame_period   = val[15:0];
         REG_NUM_FRAMES:     sheet_cfg.num_frames     = val[8:0];
         REG_FRAMES_PER_ROW: sheet_cfg.frames_per_row = val[8:0];
         REG_CYCLIC:         sheet_cfg.cyclic         = val[0];
         REG_START_X:        sheet_cfg.start_x        = val[11:0];
         REG_START_Y:        sheet_cfg.start_y        = val[11:0];
         REG_PITCH_X:        sheet_cfg.pitch_x        = val[11:0];
         default:            sheet_cfg.pitch_y        = val[11:0];
      endcase
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (val & fmask)) begin
         report_error($sformatf("readback %s got %0h want %0h",
                                idx.name(), csr_prdata, val & fmask));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // offer one request beat, hold it until taken, then log what it owes
   task automatic send_beat(input logic op, input logic [15:0] dt,
                            input bit typed, input frame_pos_type typed_want);
      frame_pos_type want;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         // gap with junk on the payload
         req_valid      <= 1'b0;
         req_op         <= 1'($urandom());
         req_delta_time <= 16'($urandom());
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_delta_time <= dt;
      do @(posedge clock); while (req_stall);
      want = step_animation(op, dt);
      pending_frames.push_back(typed ? typed_want : want);
      total_items++;
   endtask

   // drop valid and let every owed response come back
   task automatic drain_frames;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   // receiver: random stall bursts, plus the long hold-off on request
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // response checker: each taken beat against the oldest expectation
   always @(posedge clock) begin : rsp_check
      frame_pos_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report_error("response beat with nothing owed");
         end else begin
            want = pending_frames.pop_front();
            check_field("frame_index",   rsp_frame_index,   want.frame);
            check_field("pos_x",         rsp_pos_x,         want.x);
            check_field("pos_y",         rsp_pos_y,         want.y);
            check_field("finished",      rsp_finished,      want.fin);
            check_field("frame_changed", rsp_frame_changed, want.chg);
         end
      end
   end

   initial begin : stimulus
      dir_row_type   drow;
      int            phase;
      int            burst_len;
      int unsigned   period;
      logic          op;
      logic [15:0]   dt;
      logic [31:0]   val;

      sheet_cfg   = CFG_RESET;
      shown_frame = '0;
      tick_acc    = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk, random idling on
      idle_on = 1'b1;
      for (int i = 0; i < N_DIRECTED; i++) begin
         drow = DIRECTED[i];
         if (drow.kind == ROW_CSR) begin
            drain_frames();
            csr_write(drow.ridx, 32'(drow.wval));
         end else begin
            send_beat(drow.op, drow.dt, drow.kind == ROW_CHECKED, drow.want);
         end
      end
      drain_frames();

      // random phases: new settings once idle, then a burst of beats
      phase = 0;
      while (total_items < RANDOM_ITEMS) begin
         idle_on = (total_items < CALM_AFTER) && ($urandom_range(0, 2) != 0);
         for (int r = 0; r < 8; r++) begin
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
               case (reg_idx_type'(r))
                  REG_FRAME_PERIOD: begin
                     case ($urandom_range(0, 7))
                        0:       val = 0;
                        1:       val = 65535;
                        2:       val = 1;
                        6:       val = $urandom_range(1, 1000);
                        7:       val = $urandom_range(0, 65535);
                        default: val = $urandom_range(1, 40);
                     endcase
                  end
                  REG_NUM_FRAMES: begin
                     case ($urandom_range(0, 7))
                        0:       val = 0;
                        1:       val = 1;
                        2:       val = 256;
                        3:       val = $urandom_range(257, 511);
                        4:       val = $urandom_range(2, 256);
                        default: val = $urandom_range(2, 16);
                     endcase
                  end
                  REG_FRAMES_PER_ROW: begin
                     case ($urandom_range(0, 5))
                        0:       val = 0;
                        1:       val = 1;
                        2:       val = 256;
                        3:       val = $urandom_range(0, 511);
                        default: val = $urandom_range(1, 8);
                     endcase
                  end
                  REG_CYCLIC: val = $urandom_range(0, 1);
                  default: begin
                     case ($urandom_range(0, 3))
                        0:       val = 0;
                        1:       val = 4095;
                        default: val = $urandom_range(0, 4095);
                     endcase
                  end
               endcase
               csr_write(reg_idx_type'(r), val);
            end
         end

         // twice in the run the receiver sits still while beats keep coming
         if (phase == 2 || phase == 12) hold_rsp = 1'b1;

         burst_len = $urandom_range(15, 50);
         for (int k = 0; k < burst_len; k++) begin
            period = sheet_cfg.frame_period;
            // acyclic runs end up stuck, so restart them more often
            op = ($urandom_range(0, sheet_cfg.cyclic ? 11 : 3) == 0) ? OP_RESTART : OP_TICK;
            case ($urandom_range(0, 7))
               0:       dt = 16'd0;
               1:       dt = 16'hFFFF;
               2:       dt = 16'($urandom());
               3, 4:    dt = (period == 0) ? 16'($urandom()) : 16'($urandom_range(0, period));
               default: dt = (period == 0) ? 16'($urandom()) :
                              16'($urandom_range(0, (period > 32767) ? 65535 : 2 * period));
            endcase
            send_beat(op, dt, 1'b0, FP_NONE);
         end
         // settings only change once the block has gone quiet
         drain_frames();
         phase++;
      end

      // tail: let any stray beat show up before the verdict
      idle_on = 1'b0;
      drain_frames();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
